@@ sv/klce_pkg.sv @@
// shared types, field widths, codes and default sizes for the k-means engine
// no dependencies; imported by the top-level engine
package klce_pkg;

  localparam int COORD_BITS = 16;
  localparam int ERR_W      = 48;
  localparam int ITER_W     = 10;
  localparam int K_W        = 5;
  localparam int DIMS_W     = 4;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 8;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_LABEL = 2'd1;
  localparam logic [1:0] OP_CENT  = 2'd2;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_LABEL = 2'd1;
  localparam logic [1:0] KIND_CENT  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FEW      = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 2'd3;

  localparam logic [K_W-1:0]    RST_NUM_CLUSTERS = 5'd2;
  localparam logic [DIMS_W-1:0] RST_DIMS         = 4'd2;
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = 16'd26;
  localparam logic [ITER_W-1:0] RST_MAX_ITER     = 10'd255;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] coord_value;
    logic                         set_end;
    logic [9:0]                   point_index;
    logic [3:0]                   cluster_index;
    logic [2:0]                   dim_index;
  } in_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [1:0]                   status;
    logic [3:0]                   label;
    logic signed [COORD_BITS-1:0] centroid_value;
    logic [ITER_W-1:0]            iterations_used;
    logic [ERR_W-1:0]             final_error;
  } out_t;

endpackage

@@ sv/kmeans_lloyd_cluster_engine.sv @@
// k-means (lloyd) clustering engine: point load, clustering sequencer, readback
// depends on klce_pkg, klce_ram, klce_div, klce_sqrt
//
//  port group | dir     | beat carries
//  in_*       | in      | in_t: load coordinate, read label, read centroid coordinate
//  out_*      | out     | out_t: clustering finished, label answer, centroid answer
//  cfg_*      | in      | register index and write data
//
// a load beat is written when accepted; a read passes S_RD_WAIT, then S_RD_OUT
// clustering after set end runs on one distance datapath, one divider and one
// square root unit
// in_ready is low while clustering or a read runs and while a result beat waits
// reset is synchronous active low; stores hold no reset; state, load and
// iteration counters clear; config registers take their reset defaults
module kmeans_lloyd_cluster_engine #(
  parameter int MAX_POINTS   = klce_pkg::MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = klce_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = klce_pkg::MAX_DIMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  klce_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output klce_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [klce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [klce_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import klce_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int PAW     = $clog2(MAX_POINTS);
  localparam int CAW     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DAW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NW      = $clog2(MAX_POINTS + 1);
  localparam int KW      = $clog2(MAX_CLUSTERS + 1);
  localparam int EW      = $clog2(MAX_DIMS + 1);
  localparam int SW      = CB + NW;
  localparam int D2W     = 2 * CB + DAW + 1;
  localparam int SQ_IW   = D2W + (D2W % 2);
  localparam int SQ_OW   = SQ_IW / 2;
  localparam int P_DEPTH = (1 << PAW) * (1 << DAW);
  localparam int L_DEPTH = 1 << PAW;
  localparam int C_DEPTH = (1 << CAW) * (1 << DAW);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_RD_OUT, S_CP_RD, S_CP_WR,
    S_A_LAB, S_A_LABW, S_D_RD, S_D_SQ, S_D_ACC, S_A_CMP, S_A_SQ, S_CHK,
    S_U_CLR, S_U_LAB, S_U_LABW, S_U_RD, S_U_ADD,
    S_M_CNT, S_M_RD, S_M_DIV, S_M_WAIT
  } state_t;

  state_t             st_r;
  logic [PAW-1:0]     p_r;
  logic [CAW-1:0]     c_r;
  logic [DAW-1:0]     i_r;
  logic [CAW-1:0]     lab_r;
  logic [CAW-1:0]     old_r;
  logic [CAW-1:0]     best_r;
  logic [D2W-1:0]     bd_r;
  logic [D2W-1:0]     dl_r;
  logic [D2W-1:0]     acc_r;
  logic [2*CB-1:0]    sq_r;
  logic [ERR_W-1:0]   err_r;
  logic [ERR_W-1:0]   a_r;
  logic [ERR_W-1:0]   b_r;
  logic [ITER_W-1:0]  it_r;
  logic               init_r;
  logic [1:0]         op_r;
  logic               zero_r;
  logic [CAW+DAW-1:0] clr_r;
  logic               sneg_r;
  logic [NW-1:0]      pl_r;
  logic [DAW-1:0]     cip_r;
  logic               ovf_r;
  logic [K_W-1:0]     nc_r;
  logic [DIMS_W-1:0]  dims_r;
  logic [THR_W-1:0]   thr_r;
  logic [ITER_W-1:0]  maxit_r;
  out_t               out_r;
  logic               out_valid_r;
  logic [NW-1:0]      cnt_r [1 << CAW];

  logic [KW-1:0]      kk;
  logic [EW-1:0]      dd;
  logic               last_i;
  logic               last_c;
  logic               last_p;
  logic               in_acc;
  logic               room;
  logic [NW-1:0]      pl_nxt;
  logic [DAW-1:0]     cip_nxt;
  logic               ovf_nxt;
  logic [CB:0]        dif;
  logic [CB:0]        mag;
  logic               better;
  logic [D2W-1:0]     bd_nxt;
  logic [CAW-1:0]     best_nxt;
  logic [D2W-1:0]     sq_in;
  logic [ERR_W-1:0]   err_nxt;
  logic [ITER_W-1:0]  it_nxt;
  logic [ITER_W-1:0]  cap;
  logic [ERR_W-1:0]   err_diff;
  logic [SW-1:0]      s_mag;

  logic [CB-1:0]      pt_rdata;
  logic [CAW-1:0]     lab_rdata;
  logic [CB-1:0]      cen_rdata;
  logic [SW-1:0]      sum_rdata;
  logic               pt_we;
  logic               lab_we;
  logic               cen_we;
  logic [CB-1:0]      cen_wd;
  logic               sum_we;
  logic [CAW+DAW-1:0] sum_wa;
  logic [SW-1:0]      sum_wd;
  logic [CAW+DAW-1:0] sum_ra;

  logic               sq_start;
  logic               sq_done;
  logic [SQ_OW-1:0]   sq_root;
  logic               div_start;
  logic               div_done;
  logic [SW-1:0]      div_quo;

  always_comb begin
    if (nc_r == '0) begin
      kk = KW'(1);
    end else if (32'(nc_r) > MAX_CLUSTERS) begin
      kk = KW'(MAX_CLUSTERS);
    end else begin
      kk = KW'(nc_r);
    end
    if (dims_r == '0) begin
      dd = EW'(1);
    end else if (32'(dims_r) > MAX_DIMS) begin
      dd = EW'(MAX_DIMS);
    end else begin
      dd = EW'(dims_r);
    end
  end

  assign last_i = (32'(i_r) + 1) >= 32'(dd);
  assign last_c = (32'(c_r) + 1) >= 32'(kk);
  assign last_p = (32'(p_r) + 1) >= 32'(pl_r);

  assign in_ready  = (st_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_acc    = in_valid && in_ready;

  // load bookkeeping
  always_comb begin
    room    = 32'(pl_r) < MAX_POINTS;
    pl_nxt  = pl_r;
    cip_nxt = cip_r;
    ovf_nxt = ovf_r;
    if (room) begin
      if ((32'(cip_r) + 1) >= 32'(dd)) begin
        cip_nxt = '0;
        pl_nxt  = pl_r + 1'b1;
      end else begin
        cip_nxt = cip_r + 1'b1;
      end
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // distance and compare datapath
  assign dif      = {pt_rdata[CB-1], pt_rdata} - {cen_rdata[CB-1], cen_rdata};
  assign mag      = dif[CB] ? (~dif + 1'b1) : dif;
  assign better   = (c_r == '0) || (acc_r < bd_r);
  assign bd_nxt   = better ? acc_r : bd_r;
  assign best_nxt = better ? c_r : best_r;
  assign sq_in    = init_r ? bd_nxt : ((c_r == old_r) ? acc_r : dl_r);
  assign err_nxt  = err_r + ERR_W'(sq_root);
  assign it_nxt   = it_r + 1'b1;
  assign cap      = (maxit_r == '0) ? ITER_W'(1) : maxit_r;
  assign err_diff = (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);
  assign s_mag    = sum_rdata[SW-1] ? (~sum_rdata + 1'b1) : sum_rdata;

  assign sq_start  = (st_r == S_A_CMP) && last_c;
  assign div_start = (st_r == S_M_DIV);

  always_comb begin
    pt_we  = in_acc && (in_data.operation == OP_LOAD) && room;
    lab_we = (st_r == S_A_SQ) && sq_done;
    cen_we = 1'b0;
    cen_wd = pt_rdata;
    sum_we = 1'b0;
    sum_wa = {lab_r, i_r};
    sum_wd = sum_rdata + SW'($signed(pt_rdata));
    sum_ra = {lab_r, i_r};
    case (st_r)
      S_CP_WR: begin
        cen_we = 1'b1;
      end
      S_M_WAIT: begin
        cen_we = div_done;
        cen_wd = sneg_r ? CB'(~div_quo + 1'b1) : CB'(div_quo);
      end
      S_U_CLR: begin
        sum_we = 1'b1;
        sum_wa = clr_r;
        sum_wd = '0;
      end
      S_U_ADD: begin
        sum_we = 1'b1;
      end
      S_M_RD: begin
        sum_ra = {c_r, i_r};
      end
      default: begin
      end
    endcase
  end

  klce_ram #(.W(CB), .DEPTH(P_DEPTH)) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr ({pl_r[PAW-1:0], cip_r}),
    .wdata (in_data.coord_value),
    .raddr ({p_r, i_r}),
    .rdata (pt_rdata)
  );

  klce_ram #(.W(CAW), .DEPTH(L_DEPTH)) u_labels (
    .clk   (clk),
    .we    (lab_we),
    .waddr (p_r),
    .wdata (best_r),
    .raddr (p_r),
    .rdata (lab_rdata)
  );

  klce_ram #(.W(CB), .DEPTH(C_DEPTH)) u_centroids (
    .clk   (clk),
    .we    (cen_we),
    .waddr ({c_r, i_r}),
    .wdata (cen_wd),
    .raddr ({c_r, i_r}),
    .rdata (cen_rdata)
  );

  klce_ram #(.W(SW), .DEPTH(C_DEPTH)) u_sums (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_wa),
    .wdata (sum_wd),
    .raddr (sum_ra),
    .rdata (sum_rdata)
  );

  klce_sqrt #(.IN_W(SQ_IW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .din   (SQ_IW'(sq_in)),
    .done  (sq_done),
    .root  (sq_root)
  );

  klce_div #(.NUM_W(SW), .DEN_W(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (s_mag + SW'(cnt_r[c_r] >> 1)),
    .den   (cnt_r[c_r]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      pl_r        <= '0;
      cip_r       <= '0;
      ovf_r       <= 1'b0;
      init_r      <= 1'b0;
      it_r        <= '0;
      a_r         <= '0;
      b_r         <= '0;
      nc_r        <= RST_NUM_CLUSTERS;
      dims_r      <= RST_DIMS;
      thr_r       <= RST_THRESHOLD;
      maxit_r     <= RST_MAX_ITER;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_CLUSTERS: nc_r    <= cfg_data[K_W-1:0];
          REG_DIMS:         dims_r  <= cfg_data[DIMS_W-1:0];
          REG_THRESHOLD:    thr_r   <= cfg_data[THR_W-1:0];
          REG_MAX_ITER:     maxit_r <= cfg_data[ITER_W-1:0];
          default: begin
          end
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r <= in_data.operation;
            case (in_data.operation)
              OP_LOAD: begin
                pl_r  <= pl_nxt;
                cip_r <= cip_nxt;
                ovf_r <= ovf_nxt;
                if (in_data.set_end) begin
                  cip_r <= '0;
                  ovf_r <= 1'b0;
                  out_r <= '0;
                  if (ovf_nxt || (32'(pl_nxt) < 32'(kk))) begin
                    pl_r         <= '0;
                    out_r.status <= ovf_nxt ? STAT_OVERFLOW : STAT_FEW;
                    out_valid_r  <= 1'b1;
                  end else begin
                    p_r    <= '0;
                    c_r    <= '0;
                    i_r    <= '0;
                    it_r   <= '0;
                    init_r <= 1'b1;
                    st_r   <= S_CP_RD;
                  end
                end
              end
              OP_LABEL: begin
                p_r    <= PAW'(in_data.point_index);
                zero_r <= !(32'(in_data.point_index) < MAX_POINTS);
                st_r   <= S_RD_WAIT;
              end
              OP_CENT: begin
                c_r    <= CAW'(in_data.cluster_index);
                i_r    <= DAW'(in_data.dim_index);
                zero_r <= !((32'(in_data.cluster_index) < MAX_CLUSTERS) &&
                            (32'(in_data.dim_index) < MAX_DIMS));
                st_r   <= S_RD_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          st_r <= S_RD_OUT;
        end
        S_RD_OUT: begin
          out_r <= '0;
          if (op_r == OP_LABEL) begin
            out_r.kind <= KIND_LABEL;
            if (!zero_r) begin
              out_r.label <= 4'(lab_rdata);
            end
          end else begin
            out_r.kind <= KIND_CENT;
            if (!zero_r) begin
              out_r.centroid_value <= cen_rdata;
            end
          end
          out_valid_r <= 1'b1;
          st_r        <= S_IDLE;
        end
        S_CP_RD: begin
          st_r <= S_CP_WR;
        end
        S_CP_WR: begin
          if (last_i) begin
            i_r <= '0;
            if (last_c) begin
              p_r   <= '0;
              err_r <= '0;
              st_r  <= S_A_LAB;
            end else begin
              p_r  <= p_r + 1'b1;
              c_r  <= c_r + 1'b1;
              st_r <= S_CP_RD;
            end
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_CP_RD;
          end
        end
        S_A_LAB: begin
          st_r <= S_A_LABW;
        end
        S_A_LABW: begin
          old_r <= lab_rdata;
          c_r   <= '0;
          i_r   <= '0;
          acc_r <= '0;
          st_r  <= S_D_RD;
        end
        S_D_RD: begin
          st_r <= S_D_SQ;
        end
        S_D_SQ: begin
          sq_r <= mag[CB-1:0] * mag[CB-1:0];
          st_r <= S_D_ACC;
        end
        S_D_ACC: begin
          acc_r <= acc_r + D2W'(sq_r);
          if (last_i) begin
            st_r <= S_A_CMP;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_D_RD;
          end
        end
        S_A_CMP: begin
          bd_r   <= bd_nxt;
          best_r <= best_nxt;
          if (c_r == old_r) begin
            dl_r <= acc_r;
          end
          if (last_c) begin
            st_r <= S_A_SQ;
          end else begin
            c_r   <= c_r + 1'b1;
            i_r   <= '0;
            acc_r <= '0;
            st_r  <= S_D_RD;
          end
        end
        S_A_SQ: begin
          if (sq_done) begin
            err_r <= err_nxt;
            if (last_p) begin
              if (init_r) begin
                a_r    <= err_nxt;
                init_r <= 1'b0;
                clr_r  <= '0;
                st_r   <= S_U_CLR;
              end else begin
                b_r  <= a_r;
                a_r  <= err_nxt;
                st_r <= S_CHK;
              end
            end else begin
              p_r  <= p_r + 1'b1;
              st_r <= S_A_LAB;
            end
          end
        end
        S_CHK: begin
          it_r <= it_nxt;
          if ((err_diff <= ERR_W'(thr_r)) || (it_nxt >= cap)) begin
            out_r                 <= '0;
            out_r.kind            <= KIND_DONE;
            out_r.status          <= STAT_OK;
            out_r.iterations_used <= it_nxt;
            out_r.final_error     <= a_r;
            out_valid_r           <= 1'b1;
            pl_r                  <= '0;
            st_r                  <= S_IDLE;
          end else begin
            clr_r <= '0;
            st_r  <= S_U_CLR;
          end
        end
        S_U_CLR: begin
          for (int j = 0; j < (1 << CAW); j++) begin
            cnt_r[j] <= '0;
          end
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            p_r  <= '0;
            st_r <= S_U_LAB;
          end
        end
        S_U_LAB: begin
          st_r <= S_U_LABW;
        end
        S_U_LABW: begin
          lab_r            <= lab_rdata;
          cnt_r[lab_rdata] <= cnt_r[lab_rdata] + 1'b1;
          i_r              <= '0;
          st_r             <= S_U_RD;
        end
        S_U_RD: begin
          st_r <= S_U_ADD;
        end
        S_U_ADD: begin
          if (last_i) begin
            if (last_p) begin
              c_r  <= '0;
              st_r <= S_M_CNT;
            end else begin
              p_r  <= p_r + 1'b1;
              st_r <= S_U_LAB;
            end
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_U_RD;
          end
        end
        S_M_CNT: begin
          i_r <= '0;
          if (cnt_r[c_r] == '0) begin
            if (last_c) begin
              p_r   <= '0;
              err_r <= '0;
              st_r  <= S_A_LAB;
            end else begin
              c_r <= c_r + 1'b1;
            end
          end else begin
            st_r <= S_M_RD;
          end
        end
        S_M_RD: begin
          st_r <= S_M_DIV;
        end
        S_M_DIV: begin
          sneg_r <= sum_rdata[SW-1];
          st_r   <= S_M_WAIT;
        end
        S_M_WAIT: begin
          if (div_done) begin
            if (last_i) begin
              if (last_c) begin
                p_r   <= '0;
                err_r <= '0;
                st_r  <= S_A_LAB;
              end else begin
                c_r  <= c_r + 1'b1;
                st_r <= S_M_CNT;
              end
            end else begin
              i_r  <= i_r + 1'b1;
              st_r <= S_M_RD;
            end
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/klce_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module klce_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/klce_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// no dependencies; used for the centroid means
module klce_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, quo[NUM_W-1]};
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        rem_r  <= '0;
        den_r  <= den;
        quo    <= num;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DEN_W'(trial - {1'b0, den_r});
          quo   <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[DEN_W-1:0];
          quo   <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/klce_sqrt.sv @@
// iterative integer square root (floor), two radicand bits per cycle
// no dependencies; used for the point distances of the error sum
module klce_sqrt #(
  parameter int IN_W = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IN_W-1:0]   din,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  x_r;
  logic [OUT_W+1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [OUT_W+1:0] rem_sh;
  logic [OUT_W+1:0] trial;

  assign rem_sh = {rem_r[OUT_W-1:0], x_r[IN_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(OUT_W);
        x_r    <= din;
        rem_r  <= '0;
        root   <= '0;
      end else if (busy_r) begin
        if (rem_sh >= trial) begin
          rem_r <= rem_sh - trial;
          root  <= {root[OUT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root  <= {root[OUT_W-2:0], 1'b0};
        end
        x_r   <= {x_r[IN_W-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
